>>> rtl/core/crc32p_pkg.sv
// Package: reflected CRC-32 table and its top-byte inverse, built at elaboration.
package crc32p_pkg;

    localparam int unsigned TAB_DEPTH  = 256;
    localparam int unsigned CRC_W      = 32;
    localparam int unsigned WORD_W     = 2 * CRC_W;
    localparam int unsigned NUM_ROUNDS = 4;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    typedef logic [TAB_DEPTH-1:0][CRC_W-1:0] t_crc_tab;
    typedef logic [TAB_DEPTH-1:0][7:0]       t_inv_tab;
    typedef logic [WORD_W-1:0]               t_word;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [7:0] n);
        logic [CRC_W-1:0] c;
        c = {24'h0, n};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_crc_tab build_crc_tab();
        t_crc_tab t;
        for (int n = 0; n < TAB_DEPTH; n++) begin
            t[n] = crc_byte(n[7:0]);
        end
        return t;
    endfunction

    // Top bytes of the table entries form a permutation of 0..255.
    function automatic t_inv_tab build_inv_tab();
        t_inv_tab t;
        logic [CRC_W-1:0] c;
        t = '0;
        for (int n = 0; n < TAB_DEPTH; n++) begin
            c = crc_byte(n[7:0]);
            t[c[31:24]] = n[7:0];
        end
        return t;
    endfunction

    localparam t_crc_tab CRC_TAB = build_crc_tab();
    localparam t_inv_tab INV_TOP = build_inv_tab();

endpackage

>>> rtl/core/crc32p_cell.sv
// One backward round of the patch solve, registered, with its own valid bit.
module crc32p_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  crc32p_pkg::t_word    i_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output crc32p_pkg::t_word    o_word
);
    import crc32p_pkg::*;

    logic             r_valid;
    t_word            r_word;
    t_word            n_word;
    logic [7:0]       w_idx;
    logic [CRC_W-1:0] w_ent;
    t_word            w_mix;

    // Round works on the top window; the cleared top byte is shifted out
    // so the next cell sees its byte in the same place.
    always_comb begin
        w_idx  = INV_TOP[i_word[63:56]];
        w_ent  = CRC_TAB[w_idx];
        w_mix  = i_word ^ {w_ent, 32'h0} ^ {32'h0, w_idx, 24'h0};
        n_word = {w_mix[55:0], 8'h00};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> rtl/core/crc32_patch_word_solver.sv
// Top level: four-cell pipeline that solves the CRC-32 forcing patch word.
//
// Given the raw reflected CRC-32 register (poly 0xEDB88320, no inversion)
// before four patch bytes and the register wanted after them, gives the
// patch word whose bytes, low byte first, drive the CRC to the target.
// Each beat passes a chain of four identical cells, one backward round
// per cell, each cell registering its word; one beat is taken every
// cycle while o_stall is low. The last cell doubles as the output
// register; a cell whose successor is empty or moving keeps accepting, so
// bubbles collapse and new beats enter while a result waits on i_stall.
// o_stall rises only when all four cells are full and the output stalls.
module crc32_patch_word_solver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_current_crc,
    input  logic [31:0] i_target_crc,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_patch_word
);
    import crc32p_pkg::*;

    // Chain taps: index k feeds cell k; index NUM_ROUNDS is the chain end.
    logic  [NUM_ROUNDS:0] w_valid;
    logic  [NUM_ROUNDS:0] w_ready;
    t_word                w_word [NUM_ROUNDS+1];

    // Working word: current CRC low, target high.
    assign w_valid[0] = i_valid;
    assign w_word[0]  = {i_target_crc, i_current_crc};
    assign o_stall    = !w_ready[0];

    for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_cell
        crc32p_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    // After four shifted rounds the patch word sits in the upper half.
    assign w_ready[NUM_ROUNDS] = !i_stall;
    assign o_valid             = w_valid[NUM_ROUNDS];
    assign o_patch_word        = w_word[NUM_ROUNDS][63:32];

    // Input backpressure only when the whole chain is full and held.
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&w_valid[NUM_ROUNDS:1]) && i_stall)
        else $error("input stalled with room in the chain");

    // Beats in flight change only by accepted input and delivered output.
    a_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ($countones(w_valid[NUM_ROUNDS:1]) ==
            $countones($past(w_valid[NUM_ROUNDS:1]))
            + ($past(i_valid && !o_stall) ? 1 : 0)
            - ($past(o_valid && !i_stall) ? 1 : 0)))
        else $error("beat lost or duplicated in the chain");

    // An empty chain never pushes back.
    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[NUM_ROUNDS:1] == '0) |-> !o_stall)
        else $error("stall with empty chain");

endmodule

>>> tb/crc32_patch_checker.sv
// Checker for crc32_patch_word_solver: predicts each patch word and compares results.
`timescale 1ns / 1ps

module crc32_patch_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_current_crc,
    input  logic [31:0] i_target_crc,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_patch_word,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;

    logic [31:0] crc_lut [256];
    logic [7:0]  top_byte_owner [256];
    logic [31:0] expected_patches [$];
    logic [31:0] want;
    int          mismatches;

    // byte-wise CRC table and the index owning each top byte
    initial begin
        logic [31:0] c;
        for (int n = 0; n < 256; n++) begin
            c = n;
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ REFLECTED_POLY) : (c >> 1);
            end
            crc_lut[n] = c;
            top_byte_owner[c[31:24]] = n[7:0];
        end
    end

    // Unwind the four table steps from the target back onto the current value.
    function automatic logic [31:0] solve_patch_word(input logic [31:0] cur,
                                                     input logic [31:0] tgt);
        logic [63:0] w;
        logic [7:0]  idx;
        w = {tgt, cur};
        for (int r = 4; r > 0; r--) begin
            idx = top_byte_owner[w[8*(r+3) +: 8]];
            w   = w ^ ({32'h0, crc_lut[idx]} << (8 * r));
            w   = w ^ ({56'h0, idx} << (8 * (r - 1)));
        end
        return w[31:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mismatches   = 0;
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_patches.push_back(solve_patch_word(i_current_crc, i_target_crc));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_patches.size() == 0) begin
                    $error("patch_word: unexpected result beat, expected none, actual %08h",
                           i_patch_word);
                    mismatches++;
                end else begin
                    want = expected_patches.pop_front();
                    if (i_patch_word !== want) begin
                        $error("patch_word: expected %08h, actual %08h", want, i_patch_word);
                        mismatches++;
                    end
                end
            end
            o_pending    <= expected_patches.size();
            o_fail_count <= mismatches;
        end
    end

endmodule

>>> tb/testbench.sv
// Top-level bench for crc32_patch_word_solver: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;

    // receiver stall styles, picked per stretch
    typedef enum int {
        RX_FLOW   = 0,   // never stall
        RX_SPARSE = 1,   // stall about one cycle in three
        RX_BLOCK  = 2,   // solid stall for the whole stretch
        RX_COIN   = 3    // fair coin each cycle
    } t_rx_mode;

    localparam int TOTAL_BEATS  = 1350;
    localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
    localparam int FLUSH_CYCLES = 10;    // settle time after the final drain

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_current_crc;
    logic [31:0] i_target_crc;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_patch_word;

    int fail_count;
    int pending;
    bit long_hold_req;   // sender asks the receiver for a long hold-off

    crc32_patch_word_solver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_current_crc (i_current_crc),
        .i_target_crc  (i_target_crc),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_patch_word  (o_patch_word)
    );

    crc32_patch_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_current_crc (i_current_crc),
        .i_target_crc  (i_target_crc),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_patch_word  (o_patch_word),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. The slowest legal run ends well before 5 ms, so this limit
    // only trips on a hang.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Field values biased toward the corners: all zeros, all ones and
    // single bits show up far more often than plain random would give.
    function automatic logic [31:0] pick_crc_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Offer one beat and hold it until the block takes it. Returns right
    // after the accepting edge, without touching i_valid, so the caller can
    // offer the next beat in the same step with a single assignment.
    task automatic send_beat(input logic [31:0] cur, input logic [31:0] tgt);
        i_valid       <= 1'b1;
        i_current_crc <= cur;
        i_target_crc  <= tgt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Sender gap; payload goes to junk while valid is low.
    task automatic idle_cycles(input int n);
        i_valid       <= 1'b0;
        i_current_crc <= $urandom;
        i_target_crc  <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending and wait until the checker holds no expectation. The
    // first edge lets the checker's count catch up with the last accept.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver: stretches of mixed stall styles, plus a long hold-off on
    // request. At most one assignment to i_stall per clock step.
    initial begin
        t_rx_mode mode;
        int       run;
        forever begin
            if (long_hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                mode = t_rx_mode'($urandom_range(0, 3));
                run  = $urandom_range(1, 24);
                repeat (run) begin
                    case (mode)
                        RX_FLOW:   i_stall <= 1'b0;
                        RX_SPARSE: i_stall <= ($urandom_range(0, 2) == 0);
                        RX_BLOCK:  i_stall <= 1'b1;
                        default:   i_stall <= 1'($urandom_range(0, 1));
                    endcase
                    @(posedge i_clk);
                    if (long_hold_req) break;
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int sent;
        int burst;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_current_crc <= 32'h0;
        i_target_crc  <= 32'h0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, alternating patterns, walking bits
        // across every byte lane, and one full byte per lane against its
        // complement.
        send_beat(32'h0000_0000, 32'h0000_0000);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(32'hAAAA_AAAA, 32'h5555_5555);
        send_beat(32'h5555_5555, 32'hAAAA_AAAA);
        for (int k = 0; k < 8; k++) begin
            send_beat(32'h1 << (k * 4 + 3), 32'h8000_0000 >> (k * 4));
        end
        for (int k = 0; k < 4; k++) begin
            send_beat(32'hFF << (k * 8), ~(32'hFF << (k * 8)));
        end
        sent = 18;

        // Backpressure: receiver holds off while beats keep coming, so all
        // four cells fill and o_stall must rise.
        long_hold_req = 1'b1;
        repeat (30) send_beat(pick_crc_word(), pick_crc_word());
        sent += 30;

        // Sender pause until the pipe is empty, then restart from cold.
        drain_results();

        // Random bursts with random gaps; now and then a fresh hold-off or
        // a full drain so both land on varying pipeline fill levels.
        while (sent < TOTAL_BEATS) begin
            if ($urandom_range(0, 29) == 0) begin
                long_hold_req = 1'b1;
                burst = 25;
            end else begin
                burst = $urandom_range(1, 40);
            end
            repeat (burst) begin
                if (sent < TOTAL_BEATS) begin
                    send_beat(pick_crc_word(), pick_crc_word());
                    sent++;
                    // short gaps inside some bursts
                    if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 3));
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                drain_results();
            end else if ($urandom_range(0, 3) != 0) begin
                idle_cycles($urandom_range(1, 8));
            end
        end

        drain_results();
        repeat (FLUSH_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/crc32p_pkg.sv
rtl/core/crc32p_cell.sv
rtl/core/crc32_patch_word_solver.sv
tb/crc32_patch_checker.sv
tb/testbench.sv
